// ----- src/minmax_plot_decimator_assert.svh -----
// Assertion macros for the min/max plot decimator.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MINMAX_PLOT_DECIMATOR_ASSERT_SVH
`define MINMAX_PLOT_DECIMATOR_ASSERT_SVH

// same-cycle implication
`define MMPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmpd: check failed");

// next-cycle implication
`define MMPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmpd: check failed");

`endif

// ----- src/mmpd_pkg.sv -----
// Package for the min/max plot decimator: point type, queue sizing, register indexes.
// No dependencies.
`default_nettype none

package mmpd_pkg;

  localparam int FifoDepth = 8;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = PtrW + 1;
  localparam int MaxPush   = 4;

  localparam logic [2:0] CFG_BYPASS   = 3'd0;
  localparam logic [2:0] CFG_X_ORIGIN = 3'd1;
  localparam logic [2:0] CFG_X_SCALE  = 3'd2;
  localparam logic [2:0] CFG_Y_OFFSET = 3'd3;
  localparam logic [2:0] CFG_Y_SCALE  = 3'd4;

  typedef struct packed {
    logic               end_of_run;
    logic signed [15:0] row;
    logic signed [15:0] col;
  } pt_t;

endpackage

`default_nettype wire

// ----- src/minmax_plot_decimator.sv -----
// Min/max plot decimator: column/row mapping pipeline, per-column min/max bin, point queue.
// Depends on mmpd_pkg and minmax_plot_decimator_assert.svh.
//
//   channel | dir | tdata / data                        | side band
//   in_     | in  | [31:0] sample_pos, [47:32] sample_val | tlast = is_last
//   out_    | out | [15:0] col, [31:16] row               | tlast = end_of_run
//   cfg_    | in  | cfg_data, register at cfg_index      | -
//
// One sample per cycle, stalled while a sample waits at the bin stage and the queue holds
// more than four. Samples pass input, product and rounding registers, then the bin stage.
// Samples that close a bin push two or four points into an eight-entry queue drained one
// point per cycle while out_tready is high, so the sustained rate is bounded by the points
// emitted. Reset is synchronous and clears the bin, the pipeline and the queue at once.
`default_nettype none
`include "minmax_plot_decimator_assert.svh"

module minmax_plot_decimator
  import mmpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // sample_pos, sample_val
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // col, row
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic               bypass_r;
  logic [31:0]        x_origin_r;
  logic [31:0]        x_scale_r;
  logic signed [15:0] y_offset_r;
  logic signed [31:0] y_scale_r;

  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  logic [31:0]        s1_pos_r, s2_pos_r, s3_pos_r;
  logic signed [15:0] s1_val_r, s2_val_r, s3_val_r;
  logic               s1_last_r, s2_last_r, s3_last_r;
  logic [63:0]        s2_xprod_r;
  logic               s2_xneg_r;
  logic signed [47:0] s2_yprod_r;
  logic signed [15:0] s3_col_r, s3_row_r;

  logic               bin_open_r;
  logic signed [15:0] bin_col_r;
  logic signed [15:0] low_val_r, high_val_r;
  logic [31:0]        low_pos_r, high_pos_r;

  pt_t                fifo_r [FifoDepth];
  logic [PtrW-1:0]    wptr_r, rptr_r;
  logic [CntW-1:0]    fifo_cnt_r;

  logic               adv, s3_fire, pop;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r   <= 1'b0;
      x_origin_r <= 32'd0;
      x_scale_r  <= 32'd65536;
      y_offset_r <= 16'sd0;
      y_scale_r  <= 32'sd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BYPASS:   bypass_r   <= cfg_data[0];
        CFG_X_ORIGIN: x_origin_r <= cfg_data;
        CFG_X_SCALE:  x_scale_r  <= cfg_data;
        CFG_Y_OFFSET: y_offset_r <= $signed(cfg_data[15:0]);
        CFG_Y_SCALE:  y_scale_r  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline control
  assign adv       = !s3_valid_r || (fifo_cnt_r <= CntW'(MaxPush));
  assign in_tready = adv;
  assign s3_fire   = s3_valid_r && adv;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos_r  <= in_tdata[31:0];
      s1_val_r  <= $signed(in_tdata[47:32]);
      s1_last_r <= in_tlast;
    end
  end

  // stage 2: products
  logic               x_neg;
  logic [31:0]        x_mag;
  logic signed [47:0] y_prod;

  assign x_neg  = s1_pos_r < x_origin_r;
  assign x_mag  = x_neg ? (x_origin_r - s1_pos_r) : (s1_pos_r - x_origin_r);
  assign y_prod = 48'(s1_val_r) * 48'(y_scale_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_xprod_r <= 64'(x_mag) * 64'(x_scale_r);
      s2_xneg_r  <= x_neg;
      s2_yprod_r <= y_prod;
      s2_pos_r   <= s1_pos_r;
      s2_val_r   <= s1_val_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // stage 3: round and saturate
  logic [63:0]        x_rnd;
  logic [47:0]        x_q;
  logic signed [15:0] col_sat;
  logic               y_neg;
  logic [47:0]        y_mag;
  logic [47:0]        y_rnd;
  logic [31:0]        y_q;
  logic signed [33:0] y_sgn, y_sum;
  logic signed [15:0] row_sat;

  assign x_rnd = s2_xprod_r + 64'd32768;
  assign x_q   = x_rnd[63:16];

  always_comb begin
    if (s2_xneg_r) begin
      col_sat = (x_q > 48'd32768) ? 16'sh8000 : $signed(16'(16'd0 - x_q[15:0]));
    end else begin
      col_sat = (x_q > 48'd32767) ? 16'sh7fff : $signed(x_q[15:0]);
    end
  end

  assign y_neg = s2_yprod_r[47];
  assign y_mag = y_neg ? 48'(-s2_yprod_r) : 48'(s2_yprod_r);
  assign y_rnd = y_mag + 48'd32768;
  assign y_q   = y_rnd[47:16];
  assign y_sgn = y_neg ? -$signed({2'b00, y_q}) : $signed({2'b00, y_q});
  assign y_sum = y_sgn + 34'(y_offset_r);

  always_comb begin
    if (y_sum > 34'sd32767) begin
      row_sat = 16'sh7fff;
    end else if (y_sum < -34'sd32768) begin
      row_sat = 16'sh8000;
    end else begin
      row_sat = y_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_col_r  <= col_sat;
      s3_row_r  <= row_sat;
      s3_pos_r  <= s2_pos_r;
      s3_val_r  <= s2_val_r;
      s3_last_r <= s2_last_r;
    end
  end

  // stage 4: bin update and point generation
  // map the held extremes with the current row settings
  function automatic logic signed [15:0] map_row(input logic signed [15:0] v,
                                                 input logic signed [31:0] scale,
                                                 input logic signed [15:0] offset);
    logic signed [47:0] p;
    logic               neg;
    logic [47:0]        mag;
    logic [47:0]        rnd;
    logic signed [33:0] sum;
    p   = 48'(v) * 48'(scale);
    neg = p[47];
    mag = neg ? 48'(-p) : 48'(p);
    rnd = mag + 48'd32768;
    sum = neg ? -$signed({2'b00, rnd[47:16]}) : $signed({2'b00, rnd[47:16]});
    sum = sum + 34'(offset);
    if (sum > 34'sd32767) return 16'sh7fff;
    if (sum < -34'sd32768) return 16'sh8000;
    return sum[15:0];
  endfunction

  logic               hit, emit_old;
  logic               bin_open_nxt;
  logic signed [15:0] bin_col_nxt;
  logic signed [15:0] low_val_nxt, high_val_nxt, low_row_nxt, high_row_nxt;
  logic signed [15:0] low_row, high_row;
  logic [31:0]        low_pos_nxt, high_pos_nxt;
  pt_t                old_lo, old_hi, new_lo, new_hi;
  pt_t                pts [MaxPush];
  logic [2:0]         push_n;

  assign hit      = bin_open_r && (bin_col_r == s3_col_r);
  assign emit_old = bin_open_r && !hit;
  assign low_row  = map_row(low_val_r, y_scale_r, y_offset_r);
  assign high_row = map_row(high_val_r, y_scale_r, y_offset_r);

  always_comb begin
    bin_col_nxt  = bin_col_r;
    low_val_nxt  = low_val_r;
    low_pos_nxt  = low_pos_r;
    low_row_nxt  = low_row;
    high_val_nxt = high_val_r;
    high_pos_nxt = high_pos_r;
    high_row_nxt = high_row;
    if (hit) begin
      if (s3_val_r < low_val_r) begin
        low_val_nxt = s3_val_r;
        low_pos_nxt = s3_pos_r;
        low_row_nxt = s3_row_r;
      end
      if (s3_val_r > high_val_r) begin
        high_val_nxt = s3_val_r;
        high_pos_nxt = s3_pos_r;
        high_row_nxt = s3_row_r;
      end
    end else begin
      bin_col_nxt  = s3_col_r;
      low_val_nxt  = s3_val_r;
      low_pos_nxt  = s3_pos_r;
      low_row_nxt  = s3_row_r;
      high_val_nxt = s3_val_r;
      high_pos_nxt = s3_pos_r;
      high_row_nxt = s3_row_r;
    end
    bin_open_nxt = !s3_last_r;
  end

  assign old_lo = '{end_of_run: 1'b0, row: low_row,      col: bin_col_r};
  assign old_hi = '{end_of_run: 1'b0, row: high_row,     col: bin_col_r};
  assign new_lo = '{end_of_run: 1'b0, row: low_row_nxt,  col: bin_col_nxt};
  assign new_hi = '{end_of_run: 1'b0, row: high_row_nxt, col: bin_col_nxt};

  always_comb begin
    pt_t o0, o1, n0, n1;
    o0 = (low_pos_r < high_pos_r) ? old_lo : old_hi;
    o1 = (low_pos_r < high_pos_r) ? old_hi : old_lo;
    n0 = (low_pos_nxt < high_pos_nxt) ? new_lo : new_hi;
    n1 = (low_pos_nxt < high_pos_nxt) ? new_hi : new_lo;
    n1.end_of_run = 1'b1;
    if (bypass_r) begin
      pts[0] = '{end_of_run: s3_last_r, row: s3_row_r, col: s3_col_r};
      pts[1] = n0;
      pts[2] = n0;
      pts[3] = n1;
      push_n = 3'd1;
    end else begin
      if (emit_old) begin
        pts[0] = o0;
        pts[1] = o1;
      end else begin
        pts[0] = n0;
        pts[1] = n1;
      end
      pts[2] = n0;
      pts[3] = n1;
      push_n = 3'({emit_old, 1'b0}) + 3'({s3_last_r, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_open_r <= 1'b0;
      bin_col_r  <= 16'sd0;
      low_val_r  <= 16'sd0;
      low_pos_r  <= 32'd0;
      high_val_r <= 16'sd0;
      high_pos_r <= 32'd0;
    end else if (s3_fire && !bypass_r) begin
      bin_open_r <= bin_open_nxt;
      bin_col_r  <= bin_col_nxt;
      low_val_r  <= low_val_nxt;
      low_pos_r  <= low_pos_nxt;
      high_val_r <= high_val_nxt;
      high_pos_r <= high_pos_nxt;
    end
  end

  // point queue
  logic [2:0] push_cnt;

  assign push_cnt   = s3_fire ? push_n : 3'd0;
  assign out_tvalid = fifo_cnt_r != '0;
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {fifo_r[rptr_r].row, fifo_r[rptr_r].col};
  assign out_tlast  = fifo_r[rptr_r].end_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      rptr_r     <= '0;
      fifo_cnt_r <= '0;
    end else begin
      wptr_r     <= wptr_r + PtrW'(push_cnt);
      rptr_r     <= rptr_r + PtrW'(pop);
      fifo_cnt_r <= fifo_cnt_r + CntW'(push_cnt) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxPush; i++) begin
      if (3'(i) < push_cnt) begin
        fifo_r[wptr_r + PtrW'(i)] <= pts[i];
      end
    end
  end

  `MMPD_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt_r <= CntW'(FifoDepth))
  `MMPD_ASSERT_NXT(a_stall_hold, s3_valid_r && !adv, s3_valid_r && $stable(s3_col_r))
  `MMPD_ASSERT_NXT(a_last_closes, s3_fire && !bypass_r && s3_last_r, !bin_open_r)
  `MMPD_ASSERT_NOW(a_bin_order, bin_open_r, low_val_r <= high_val_r)

endmodule

`default_nettype wire

// ----- sim/minmax_plot_decimator_tb.sv -----
// Testbench for minmax_plot_decimator: drives sample streams under several register
// settings and checks every emitted screen point against table values or an in-bench min/max bin model.
// Depends on mmpd_pkg and the decimator RTL only.
`timescale 1ns / 100ps

module minmax_plot_decimator_tb;
  import mmpd_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 5;
  localparam int RAND_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 53;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 12;
  localparam int TAIL_CYCLES     = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic               byp;
    logic [31:0]        org;
    logic [31:0]        xs;
    logic signed [15:0] yoff;
    logic signed [31:0] ys;
  } scope_cfg_t;

  typedef struct {
    int                 sect;
    logic [31:0]        pos;
    logic signed [15:0] val;
    logic               last;
    logic               typed;
    logic signed [15:0] ecol;
    logic signed [15:0] erow;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = CFG_BYPASS;
  logic [31:0] cfg_data = '0;
  wire logic        in_tready;
  wire logic        out_tvalid;
  wire logic [31:0] out_tdata;
  wire logic        out_tlast;
  wire logic        cfg_ready;

  minmax_plot_decimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] sample_pos, [47:32] sample_val
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [15:0] col, [31:16] row
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // display mapping and open bin as the block should hold them
  scope_cfg_t         cur_cfg;
  logic               bin_open = 1'b0;
  logic signed [15:0] bin_col = '0;
  logic signed [15:0] lo_val = '0;
  logic signed [15:0] hi_val = '0;
  logic [31:0]        lo_pos = '0;
  logic [31:0]        hi_pos = '0;
  pt_t                pending_pts[$];

  int          tx_idle_pct = 25;
  int          rx_idle_pct = 67;
  int          stall_kick = 0;
  int          kick_seen = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  int          mismatches = 0;
  int          pts_checked = 0;
  int          samples_sent = 0;
  int          cfg_sets = 0;
  int          held_cycles = 0;

  scope_cfg_t sect_cfg[2];
  scope_cfg_t rand_cfg[RAND_PHASES];

  dir_row_t dir_tab[25] = '{
    '{0, 32'd0,          16'sd0,      1'b0, 1'b1, 16'sd0,     16'sd0},
    '{0, 32'd32767,      16'sd32767,  1'b0, 1'b1, 16'sd32767, 16'sd32767},
    '{0, 32'd32768,      16'sh8000,   1'b0, 1'b1, 16'sd32767, 16'sh8000},
    '{0, 32'hFFFF_FFFF,  -16'sd1,     1'b1, 1'b1, 16'sd32767, -16'sd1},
    '{0, 32'd1,          16'sd1,      1'b1, 1'b1, 16'sd1,     16'sd1},
    '{0, 32'h8000_0000,  16'sd21845,  1'b0, 1'b1, 16'sd32767, 16'sd21845},
    '{1, 32'd100,        16'sd5,      1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd101,        -16'sd7,     1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd101,        16'sd20,     1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd100,        16'sd20,     1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd101,        -16'sd7,     1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd102,        16'sd0,      1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd103,        -16'sd100,   1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd104,        16'sd300,    1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd106,        16'sd1,      1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd106,        16'sd32767,  1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd107,        16'sh8000,   1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd107,        16'sd0,      1'b1, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd200,        16'sd42,     1'b1, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd50,         -16'sd1,     1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd0,          16'sd2,      1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'hFFFF_FFFF,  16'sd32767,  1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'hFFFF_FFFF,  16'sh8000,   1'b0, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'd5000,       16'sd7,      1'b1, 1'b0, 16'sd0,     16'sd0},
    '{1, 32'hFFFF_0000,  -16'sd3,     1'b1, 1'b0, 16'sd0,     16'sd0}
  };

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sd32767;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] column_of(input logic [31:0] pos);
    logic [31:0]        diff;
    logic [63:0]        q;
    logic signed [63:0] s;
    diff = (pos >= cur_cfg.org) ? pos - cur_cfg.org : cur_cfg.org - pos;
    q = ({32'd0, diff} * {32'd0, cur_cfg.xs} + 64'd32768) >> 16;
    s = $signed(q);
    if (pos < cur_cfg.org) s = -s;
    return sat16(s);
  endfunction

  function automatic logic signed [15:0] row_of(input logic signed [15:0] val);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] p;
    logic signed [63:0] r;
    logic [63:0]        mag;
    a = val;
    b = cur_cfg.ys;
    p = a * b;
    mag = (p < 0) ? -p : p;
    r = $signed((mag + 64'd32768) >> 16);
    if (p < 0) r = -r;
    return sat16(r + cur_cfg.yoff);
  endfunction

  function automatic void push_point(input logic signed [15:0] c, input logic signed [15:0] r,
                                     input logic eor);
    pt_t p;
    p.col = c;
    p.row = r;
    p.end_of_run = eor;
    pending_pts.push_back(p);
  endfunction

  function automatic void flush_bin(input logic eor);
    logic signed [15:0] rl;
    logic signed [15:0] rh;
    rl = row_of(lo_val);
    rh = row_of(hi_val);
    if (lo_pos < hi_pos) begin
      push_point(bin_col, rl, 1'b0);
      push_point(bin_col, rh, eor);
    end else begin
      push_point(bin_col, rh, 1'b0);
      push_point(bin_col, rl, eor);
    end
  endfunction

  function automatic void decimate_sample(input logic [31:0] pos, input logic signed [15:0] val,
                                          input logic last);
    logic signed [15:0] c;
    c = column_of(pos);
    if (cur_cfg.byp) begin
      push_point(c, row_of(val), last);
      return;
    end
    if (bin_open && bin_col == c) begin
      if (val < lo_val) begin
        lo_val = val;
        lo_pos = pos;
      end
      if (val > hi_val) begin
        hi_val = val;
        hi_pos = pos;
      end
    end else begin
      if (bin_open) flush_bin(1'b0);
      bin_open = 1'b1;
      bin_col = c;
      lo_val = val;
      lo_pos = pos;
      hi_val = val;
      hi_pos = pos;
    end
    if (last) begin
      flush_bin(1'b1);
      bin_open = 1'b0;
    end
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_cfg(input scope_cfg_t s);
    cfg_write(CFG_BYPASS, {31'd0, s.byp});
    cfg_write(CFG_X_ORIGIN, s.org);
    cfg_write(CFG_X_SCALE, s.xs);
    cfg_write(CFG_Y_OFFSET, 32'(s.yoff));
    cfg_write(CFG_Y_SCALE, s.ys);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_cfg = s;
    cfg_sets++;
  endtask

  task automatic send_sample(input logic [31:0] pos, input logic signed [15:0] val,
                             input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {val, pos};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // hold the input until every pending point is out and the pipeline has emptied
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void report(input string msg);
    if (mismatches < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  always @(negedge clk) begin
    if (kick_seen != stall_kick) begin
      kick_seen = stall_kick;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points pending", cycle_count, pending_pts.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    pt_t got;
    pt_t want;
    if (rst_n && in_tvalid && !in_tready) held_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got.col = out_tdata[15:0];
      got.row = out_tdata[31:16];
      got.end_of_run = out_tlast;
      if (pending_pts.size() == 0) begin
        report($sformatf("unexpected point col %0d row %0d end %0b",
                         got.col, got.row, got.end_of_run));
      end else begin
        want = pending_pts.pop_front();
        pts_checked++;
        if (got.col !== want.col || got.row !== want.row ||
            got.end_of_run !== want.end_of_run)
          report($sformatf("point %0d: expected col %0d row %0d end %0b, got col %0d row %0d end %0b",
                           pts_checked, want.col, want.row, want.end_of_run,
                           got.col, got.row, got.end_of_run));
      end
    end
  end

  initial begin
    logic [31:0]        cur_pos;
    logic signed [15:0] val;
    logic               last;
    int                 pick;

    cur_cfg = '{1'b0, 32'd0, 32'h0001_0000, 16'sd0, 32'sh0001_0000};
    sect_cfg[0] = '{1'b1, 32'd0, 32'h0001_0000, 16'sd0, 32'sh0001_0000};
    sect_cfg[1] = '{1'b0, 32'd100, 32'h0000_4000, 16'sd10, 32'shFFFF_0000};
    rand_cfg[0] = '{1'b0, $urandom, 32'h0000_2000, 16'sd0, 32'sh0001_0000};
    rand_cfg[1] = '{1'b0, 32'd0, 32'h0000_0000, 16'sh8000, 32'sh7FFF_FFFF};
    rand_cfg[2] = '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd32767, 32'sh8000_0000};
    rand_cfg[3] = '{1'b0, $urandom, $urandom_range(32'h0004_0000), 16'($urandom), $urandom};
    rand_cfg[4] = '{1'b0, $urandom, 32'h0000_4000, 16'($urandom), 32'sh0000_8000};
    rand_cfg[5] = '{1'b0, $urandom, 32'h0000_8000, 16'sd0, 32'shFFFE_0000};
    rand_cfg[6] = '{1'b1, $urandom, $urandom, 16'($urandom), $urandom};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(dir_tab); i++) begin
      if (i == 0 || dir_tab[i].sect != dir_tab[i-1].sect) begin
        wait_drain();
        apply_cfg(sect_cfg[dir_tab[i].sect]);
      end
      send_sample(dir_tab[i].pos, dir_tab[i].val, dir_tab[i].last);
      if (dir_tab[i].typed) push_point(dir_tab[i].ecol, dir_tab[i].erow, dir_tab[i].last);
      else decimate_sample(dir_tab[i].pos, dir_tab[i].val, dir_tab[i].last);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drain();
      tx_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 67 : 0;
      rx_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 25 : 0;
      apply_cfg(rand_cfg[ph]);
      if (ph == 4) stall_kick++;
      cur_pos = rand_cfg[ph].org - 32'($urandom_range(32));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) wait_drain();
        pick = $urandom_range(99);
        if (pick < 70) cur_pos += $urandom_range(4);
        else if (pick < 85) cur_pos += $urandom_range(200, 5);
        else if (pick < 92) cur_pos = $urandom;
        else cur_pos -= $urandom_range(50, 1);
        pick = $urandom_range(99);
        val = (pick < 10) ? 16'sh7FFF : (pick < 20) ? 16'sh8000 : 16'($urandom);
        last = ($urandom_range(99) < 6);
        send_sample(cur_pos, val, last);
        decimate_sample(cur_pos, val, last);
        if (last && $urandom_range(1)) cur_pos = rand_cfg[ph].org + $urandom_range(64) - 16;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d samples over %0d register settings, %0d points checked, %0d mismatches",
             samples_sent, cfg_sets, pts_checked, mismatches);
    $display("Summary: input back-pressured %0d cycles, one output hold of %0d cycles",
             held_cycles, HOLD_CYCLES);
    if (mismatches == 0 && pending_pts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/mmpd_pkg.sv
src/minmax_plot_decimator.sv
sim/minmax_plot_decimator_tb.sv
